// ----- rtl/core/nmet_pkg.sv -----
// Shared constants and types for the neighbourhood mean edge threshold block.
package nmet_pkg;

  // Channel and field widths
  localparam int unsigned ChanW      = 8;
  localparam int unsigned RgbW       = 3 * ChanW;
  localparam int unsigned PixelW     = 32;
  localparam int unsigned FrameWidthW  = 12;
  localparam int unsigned FrameHeightW = 13;
  localparam int unsigned ThresholdW = 9;
  localparam int unsigned RowW       = 12;
  localparam int unsigned OutColW    = 11;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 13;
  localparam int unsigned NbCount    = 8;
  localparam int unsigned SumW       = ChanW + $clog2(NbCount);

  // Geometry
  localparam int unsigned DefaultMaxWidth = 2048;
  localparam logic [FrameHeightW-1:0] MaxRows = 13'd4096;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegFrameWidth    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFrameHeight   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegDiffThreshold = 2'd2;

  // Register reset values
  localparam logic [FrameWidthW-1:0]  FrameWidthRst    = 12'd640;
  localparam logic [FrameHeightW-1:0] FrameHeightRst   = 13'd480;
  localparam logic [ThresholdW-1:0]   DiffThresholdRst = 9'd32;

  // Result pixels
  localparam logic [PixelW-1:0] DarkPixel  = 32'hff00_0000;
  localparam logic [PixelW-1:0] LightPixel = 32'hffff_ffff;

  typedef logic [RgbW-1:0] rgb_t;

  // 3x3 window handed to the decision logic
  typedef struct packed {
    logic [NbCount-1:0][RgbW-1:0] nb;
    rgb_t                         centre;
    logic [ThresholdW-1:0]        threshold;
  } nmet_window_t;

endpackage

// ----- rtl/core/nmet_decide.sv -----
// Per-channel neighbour mean and threshold compare for one 3x3 window.
module nmet_decide (
  input  nmet_pkg::nmet_window_t win_i,
  output logic                   is_dark_o
);
  import nmet_pkg::*;

  logic [SumW-1:0]  sum;
  logic [ChanW-1:0] mean;
  logic [ChanW-1:0] cen;
  logic [ChanW-1:0] diff;
  logic             dark;

  always_comb begin
    dark = 1'b0;
    sum  = '0;
    mean = '0;
    cen  = '0;
    diff = '0;
    for (int ch = 0; ch < 3; ch++) begin
      sum = '0;
      for (int k = 0; k < NbCount; k++) begin
        sum = sum + SumW'(win_i.nb[k][ch*ChanW +: ChanW]);
      end
      // floor mean of eight neighbours
      mean = sum[SumW-1 -: ChanW];
      cen  = win_i.centre[ch*ChanW +: ChanW];
      diff = (mean >= cen) ? (mean - cen) : (cen - mean);
      if ({1'b0, diff} >= win_i.threshold) begin
        dark = 1'b1;
      end
    end
  end

  assign is_dark_o = dark;

endmodule

// ----- rtl/core/neighbourhood_mean_edge_threshold.sv -----
// Top level: 3x3 neighbour mean edge threshold over a raster ARGB pixel stream.
//
//  Channel | Handshake               | Payload
//  --------+-------------------------+---------------------------------------------
//  in      | in_valid_i / in_ready_o | pixel_in_i, frame_start_i
//  out     | out_valid_o/out_ready_i | out_row_o, out_col_o, is_dark_o, pixel_out_o
//  cfg     | cfg_we_i (no wait)      | cfg_idx_i, cfg_wdata_i
//
// One pixel request per clock sustained unless the output stalls. An accepted
// request reads its line buffer entry as it enters the decision stage; when that
// stage advances, it is decided, written back and loaded into the output register.
// One read and one write of the single line buffer per cycle set the rate.
// Reset clears counters, window and valid flags; the line buffer is not cleared.
// A stalled result stalls the decision stage only when it holds an interior pixel.
module neighbourhood_mean_edge_threshold #(
  parameter int unsigned MAX_WIDTH = nmet_pkg::DefaultMaxWidth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [nmet_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [nmet_pkg::CfgDataW-1:0]     cfg_wdata_i,
  // pixel requests
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [nmet_pkg::PixelW-1:0]       pixel_in_i,
  input  logic                              frame_start_i,
  // decided centre pixels
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [nmet_pkg::RowW-1:0]         out_row_o,
  output logic [nmet_pkg::OutColW-1:0]      out_col_o,
  output logic                              is_dark_o,
  output logic [nmet_pkg::PixelW-1:0]       pixel_out_o
);
  import nmet_pkg::*;

  // Column index width, and a width that holds the effective line width
  localparam int unsigned ColW = $clog2(MAX_WIDTH);
  localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned EW   = (WW > FrameWidthW) ? WW : FrameWidthW;
  localparam int unsigned MemW = 2 * RgbW;

  localparam logic [EW-1:0]           WidthCap = EW'(MAX_WIDTH);
  localparam logic [EW-1:0]           EwOne    = EW'(1);
  localparam logic [EW:0]             EwTwo    = (EW + 1)'(2);
  localparam logic [EW-1:0]           EwThree  = EW'(3);
  localparam logic [FrameHeightW-1:0] RhOne    = FrameHeightW'(1);
  localparam logic [FrameHeightW-1:0] RhTwo    = FrameHeightW'(2);
  localparam logic [FrameHeightW-1:0] RhThree  = FrameHeightW'(3);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [FrameWidthW-1:0]  frame_width_q;
  logic [FrameHeightW-1:0] frame_height_q;
  logic [ThresholdW-1:0]   diff_threshold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q    <= FrameWidthRst;
      frame_height_q   <= FrameHeightRst;
      diff_threshold_q <= DiffThresholdRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegFrameWidth:    frame_width_q    <= cfg_wdata_i[FrameWidthW-1:0];
        RegFrameHeight:   frame_height_q   <= cfg_wdata_i[FrameHeightW-1:0];
        RegDiffThreshold: diff_threshold_q <= cfg_wdata_i[ThresholdW-1:0];
        default: ;
      endcase
    end
  end

  // Effective geometry: cap to the storage and the row range, treat zero as one
  logic [EW-1:0]           eff_w;
  logic [EW-1:0]           fw_ext;
  logic [FrameHeightW-1:0] eff_h;

  always_comb begin
    fw_ext = EW'(frame_width_q);
    if (fw_ext > WidthCap) begin
      eff_w = WidthCap;
    end else if (fw_ext == '0) begin
      eff_w = EwOne;
    end else begin
      eff_w = fw_ext;
    end
    if (frame_height_q > MaxRows) begin
      eff_h = MaxRows;
    end else if (frame_height_q == '0) begin
      eff_h = RhOne;
    end else begin
      eff_h = frame_height_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Raster position of the arriving pixel
  // ---------------------------------------------------------------------------
  logic [RowW-1:0]         row_q, row_d;
  logic [ColW-1:0]         col_q, col_d;
  logic [FrameHeightW-1:0] row_base, row_wrap, row_cur, row_inc;
  logic [EW-1:0]           col_base, col_cur, col_inc;
  logic                    interior;
  logic                    in_accept;

  always_comb begin
    row_base = frame_start_i ? '0 : FrameHeightW'(row_q);
    col_base = frame_start_i ? '0 : EW'(col_q);
    // a width that shrank mid-line wraps to the next line first
    if (col_base >= eff_w) begin
      col_cur  = '0;
      row_wrap = row_base + RhOne;
    end else begin
      col_cur  = col_base;
      row_wrap = row_base;
    end
    row_cur = (row_wrap >= eff_h) ? '0 : row_wrap;

    // advance the counters past this pixel
    col_inc = col_cur + EwOne;
    row_inc = row_cur + RhOne;
    if (col_inc >= eff_w) begin
      col_d = '0;
      row_d = (row_inc >= eff_h) ? '0 : row_inc[RowW-1:0];
    end else begin
      col_d = col_inc[ColW-1:0];
      row_d = row_cur[RowW-1:0];
    end

    interior = (row_cur >= RhThree) && ((row_cur + RhTwo) <= eff_h) &&
               (col_cur >= EwThree) && (({1'b0, col_cur} + EwTwo) <= {1'b0, eff_w});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (in_accept) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Decision stage and line buffer
  // ---------------------------------------------------------------------------
  logic             s1_valid_q;
  logic             s1_int_q;
  rgb_t             s1_pix_q;
  logic [RowW-1:0]  s1_row_q;
  logic [ColW-1:0]  s1_col_q;
  logic             s1_go;
  logic             s1_adv;

  logic             out_valid_q;
  logic [RowW-1:0]  out_row_q;
  logic [OutColW-1:0] out_col_q;
  logic             is_dark_q;

  // Proceed when the stage makes no result or the output register frees up
  assign s1_go      = !s1_int_q || !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && s1_go;
  assign in_ready_o = !s1_valid_q || s1_go;
  assign in_accept  = in_valid_i && in_ready_o;

  // One entry per column: {line two above, line above}
  logic [MemW-1:0] line_mem [MAX_WIDTH];
  logic [MemW-1:0] rd_q;
  logic            fwd_q;
  rgb_t            fwd_top_q, fwd_mid_q;
  rgb_t            s1_top, s1_mid;

  // Take forwarded lines when the write back of the previous pixel hit this column
  assign s1_top = fwd_q ? fwd_top_q : rd_q[MemW-1 -: RgbW];
  assign s1_mid = fwd_q ? fwd_mid_q : rd_q[RgbW-1:0];

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      rd_q <= line_mem[col_cur[ColW-1:0]];
    end
    if (s1_adv) begin
      line_mem[s1_col_q] <= {s1_mid, s1_pix_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (in_accept) begin
      fwd_q <= s1_adv && (s1_col_q == col_cur[ColW-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      fwd_top_q <= s1_mid;
      fwd_mid_q <= s1_pix_q;
      s1_pix_q  <= pixel_in_i[RgbW-1:0];
      s1_row_q  <= row_cur[RowW-1:0];
      s1_col_q  <= col_cur[ColW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_int_q   <= 1'b0;
    end else begin
      s1_valid_q <= in_accept || (s1_valid_q && !s1_go);
      if (in_accept) begin
        s1_int_q <= interior;
      end else if (s1_go) begin
        s1_int_q <= 1'b0;
      end
    end
  end

  // Window columns: [0..2] one column left (top, middle, bottom), [3..5] two left
  rgb_t win_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_adv) begin
      win_q[3] <= win_q[0];
      win_q[4] <= win_q[1];
      win_q[5] <= win_q[2];
      win_q[0] <= s1_top;
      win_q[1] <= s1_mid;
      win_q[2] <= s1_pix_q;
    end
  end

  nmet_window_t win;
  logic         dark;

  always_comb begin
    win.nb[0]     = win_q[3];
    win.nb[1]     = win_q[4];
    win.nb[2]     = win_q[5];
    win.nb[3]     = win_q[0];
    win.nb[4]     = win_q[2];
    win.nb[5]     = s1_top;
    win.nb[6]     = s1_mid;
    win.nb[7]     = s1_pix_q;
    win.centre    = win_q[1];
    win.threshold = diff_threshold_q;
  end

  nmet_decide u_decide (
    .win_i     (win),
    .is_dark_o (dark)
  );

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic [RowW-1:0] row_m1;
  logic [ColW-1:0] col_m1;

  assign row_m1 = s1_row_q - RowW'(1);
  assign col_m1 = s1_col_q - ColW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_int_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_int_q) begin
      out_row_q <= row_m1;
      out_col_q <= OutColW'(col_m1);
      is_dark_q <= dark;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign is_dark_o   = is_dark_q;
  assign pixel_out_o = is_dark_q ? DarkPixel : LightPixel;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // A stalled decision stage keeps its pixel and column
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_go |=> s1_valid_q && $stable(s1_col_q) && $stable(s1_pix_q))
    else $error("decision stage lost a stalled pixel");

  // The accepted column always lies inside the effective line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |-> col_cur < eff_w)
    else $error("column outside the line");

  // Forwarding only follows a write back in the same cycle as the read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q && $past(in_accept) |-> $past(s1_adv))
    else $error("forwarding without a write back");

  // Results only come from interior pixels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> out_row_o >= RowW'(2) && out_col_o >= OutColW'(2))
    else $error("result for a border pixel");

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the neighbourhood mean edge threshold block.
module testbench;
  import nmet_pkg::*;

  localparam int unsigned LineMax      = DefaultMaxWidth;
  localparam int unsigned ChanCount    = RgbW / ChanW;
  localparam int          ChanMax      = (1 << ChanW) - 1;
  localparam int unsigned SettleCycles = 8;      // pipeline depth plus margin
  localparam int unsigned EndCycles    = 20;
  localparam int unsigned QuietLimit   = 5000;   // cycles with no request moving
  localparam int unsigned SpikePct     = 4;

  // Expected decision for one interior centre pixel
  typedef struct packed {
    logic [RowW-1:0]    row;
    logic [OutColW-1:0] col;
    logic               dark;
    logic [PixelW-1:0]  pixel;
  } centre_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = RegFrameWidth;
  logic [CfgDataW-1:0] cfg_wdata_i   = '0;
  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic [PixelW-1:0]   pixel_in_i    = '0;
  logic                frame_start_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i   = 1'b0;
  logic [RowW-1:0]     out_row_o;
  logic [OutColW-1:0]  out_col_o;
  logic                is_dark_o;
  logic [PixelW-1:0]   pixel_out_o;

  neighbourhood_mean_edge_threshold #(
    .MAX_WIDTH(LineMax)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .pixel_in_i   (pixel_in_i),
    .frame_start_i(frame_start_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .is_dark_o    (is_dark_o),
    .pixel_out_o  (pixel_out_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the block: register copies, line stores, window and raster counters
  // ---------------------------------------------------------------------------
  logic [FrameWidthW-1:0]  frame_w_reg = FrameWidthRst;
  logic [FrameHeightW-1:0] frame_h_reg = FrameHeightRst;
  logic [ThresholdW-1:0]   thresh_reg  = DiffThresholdRst;

  rgb_t        row_above     [LineMax];
  rgb_t        row_two_above [LineMax];
  // slots 0..2: column col-1 (top, middle, bottom); slots 3..5: column col-2
  rgb_t        window_rgb [6] = '{default: '0};
  int unsigned cur_row = 0;
  int unsigned cur_col = 0;

  centre_t     pending_centres [$];

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_request  = 0;
  int          hold_left     = 0;
  int          fault_count   = 0;
  int unsigned quiet_cycles  = 0;

  // Dark when the floor mean of the eight neighbours strays from the centre by
  // the threshold or more in any of red, green or blue.
  function automatic logic centre_is_dark(input rgb_t nb [NbCount], input rgb_t centre);
    int sum, mean, c, d, ch, k;
    logic dark;
    dark = 1'b0;
    for (ch = 0; ch < ChanCount; ch++) begin
      sum = 0;
      for (k = 0; k < NbCount; k++) sum += int'(nb[k][ch*ChanW +: ChanW]);
      mean = sum / NbCount;
      c    = int'(centre[ch*ChanW +: ChanW]);
      d    = (mean >= c) ? mean - c : c - mean;
      if (d >= int'(thresh_reg)) dark = 1'b1;
    end
    return dark;
  endfunction

  // Advance the shadow raster by one accepted pixel request; queue the decision
  // for the centre one line up and one column left when it is interior.
  task automatic take_pixel(input logic [PixelW-1:0] pix, input logic fs);
    int unsigned w, h, row, col;
    rgb_t        rgb, top, mid;
    rgb_t        nb [NbCount];
    centre_t     res;
    rgb = pix[RgbW-1:0];
    w = int'(frame_w_reg);
    if (w > LineMax) w = LineMax;
    if (w == 0) w = 1;
    h = int'(frame_h_reg);
    if (h > int'(MaxRows)) h = int'(MaxRows);
    if (h == 0) h = 1;

    if (fs) begin
      cur_row = 0;
      cur_col = 0;
    end
    if (cur_col >= w) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row >= h) cur_row = 0;
    row = cur_row;
    col = cur_col;
    top = row_two_above[col];
    mid = row_above[col];

    if (row >= 3 && row + 2 <= h && col >= 3 && col + 2 <= w) begin
      nb = '{window_rgb[3], window_rgb[4], window_rgb[5], window_rgb[0], window_rgb[2],
             top, mid, rgb};
      res.row   = RowW'(row - 1);
      res.col   = OutColW'(col - 1);
      res.dark  = centre_is_dark(nb, window_rgb[1]);
      res.pixel = res.dark ? DarkPixel : LightPixel;
      pending_centres.push_back(res);
    end

    // shift the window one column and refresh the line stores from raw input
    window_rgb[3] = window_rgb[0];
    window_rgb[4] = window_rgb[1];
    window_rgb[5] = window_rgb[2];
    window_rgb[0] = top;
    window_rgb[1] = mid;
    window_rgb[2] = rgb;
    row_two_above[col] = mid;
    row_above[col]     = rgb;

    cur_col = col + 1;
    if (cur_col >= w) begin
      cur_col = 0;
      cur_row = row + 1;
      if (cur_row >= h) cur_row = 0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready pattern, hold-off, and the comparison against the queue
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      // hold off: let the block fill up and stall its input
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    centre_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_centres.size() == 0) begin
        fault_count++;
        $display("%0t: unexpected result request, row %0d col %0d dark %b pixel %h",
                 $time, out_row_o, out_col_o, is_dark_o, pixel_out_o);
      end else begin
        want = pending_centres.pop_front();
        if (want.row !== out_row_o || want.col !== out_col_o ||
            want.dark !== is_dark_o || want.pixel !== pixel_out_o) begin
          fault_count++;
          $display("%0t: expected row %0d col %0d dark %b pixel %h, got row %0d col %0d dark %b pixel %h",
                   $time, want.row, want.col, want.dark, want.pixel,
                   out_row_o, out_col_o, is_dark_o, pixel_out_o);
        end
      end
    end
  end

  // Watchdog: abandon the run when no request moves on either side for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("neighbourhood_mean_edge_threshold verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Request side helpers
  // ---------------------------------------------------------------------------

  // Offer one pixel request, after a random gap, and hold it until taken.
  task automatic send_pixel(input logic [PixelW-1:0] pix, input logic fs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pixel_in_i    <= pix;
    frame_start_i <= fs;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    take_pixel(pix, fs);
  endtask

  // Drop valid, wait for every queued decision, then let the pipeline empty out
  // (pixels on the border leave nothing in the queue yet may still be in flight).
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_centres.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      RegFrameWidth:    frame_w_reg = data[FrameWidthW-1:0];
      RegFrameHeight:   frame_h_reg = data[FrameHeightW-1:0];
      RegDiffThreshold: thresh_reg  = data[ThresholdW-1:0];
      default: ;
    endcase
  endtask

  // Reprogram the geometry and threshold while idle; spare data bits get noise.
  task automatic set_frame(input int unsigned w, input int unsigned h, input int unsigned thr);
    logic [CfgDataW-1:0] d;
    drain();
    d = CfgDataW'($urandom);
    d[FrameWidthW-1:0] = w[FrameWidthW-1:0];
    write_reg(RegFrameWidth, d);
    write_reg(RegFrameHeight, h[CfgDataW-1:0]);
    d = CfgDataW'($urandom);
    d[ThresholdW-1:0] = thr[ThresholdW-1:0];
    write_reg(RegDiffThreshold, d);
    cfg_we_i <= 1'b0;
  endtask

  // A colour near base in each channel, clamped; alpha is pure noise.
  function automatic logic [PixelW-1:0] near_colour(input rgb_t base, input int unsigned spread);
    logic [PixelW-1:0] pix;
    int v, ch;
    pix = $urandom;
    for (ch = 0; ch < ChanCount; ch++) begin
      v = int'(base[ch*ChanW +: ChanW]) + int'($urandom_range(2 * spread)) - int'(spread);
      if (v < 0) v = 0;
      else if (v > ChanMax) v = ChanMax;
      pix[ch*ChanW +: ChanW] = v[ChanW-1:0];
    end
    return pix;
  endfunction

  // Stream npix pixels; smooth frames sit near one colour with rare spikes.
  task automatic send_frame(input int unsigned npix, input bit mark_start, input bit smooth,
                            input int unsigned spread);
    rgb_t              base;
    logic [PixelW-1:0] pix;
    int unsigned       i;
    base = rgb_t'($urandom);
    for (i = 0; i < npix; i++) begin
      if (smooth && $urandom_range(99) >= SpikePct) pix = near_colour(base, spread);
      else pix = $urandom;
      send_pixel(pix, mark_start && i == 0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Smallest frames: a single interior centre, exactly at and just under the
  // threshold, with all-zero and all-one pixels on the border.
  task automatic test_minimal_frames();
    logic [PixelW-1:0] pix;
    int r, c, f;
    // a few pixels under the reset geometry: first row, nothing decided
    for (c = 0; c < 8; c++) send_pixel($urandom, c == 0);
    set_frame(5, 5, 32);
    for (f = 0; f < 2; f++) begin
      for (r = 0; r < 5; r++) begin
        for (c = 0; c < 5; c++) begin
          pix = LightPixel;
          if (r == 2 && c == 2) pix = (f == 0) ? 32'h00ff_ffdf : 32'h00e0_ffff;
          if (r == 1 && c == 1) pix = 32'h80ff_ffff;
          if ((r == 0 && c == 0) || (r == 4 && c == 4)) pix = '0;
          send_pixel(pix, r == 0 && c == 0);
        end
      end
    end
  endtask

  // Threshold 0 darkens even a flat frame; 256 and above never darken.
  task automatic test_threshold_extremes();
    int unsigned thr_set [4] = '{0, 255, 256, 511};
    logic [PixelW-1:0] pix;
    int i, r, c;
    for (i = 0; i < 4; i++) begin
      set_frame(5, 5, thr_set[i]);
      for (r = 0; r < 5; r++) begin
        for (c = 0; c < 5; c++) begin
          if (thr_set[i] == 0) pix = 32'h1234_5678;
          else pix = (r == 2 && c == 2) ? '0 : LightPixel;
          send_pixel(pix, r == 0 && c == 0);
        end
      end
    end
  endtask

  // Widths and heights below five, zero included, decide nothing at all.
  task automatic test_degenerate_geometry();
    int unsigned geo_w [6] = '{0, 1, 4, 9, 7, 3};
    int unsigned geo_h [6] = '{6, 5, 9, 4, 0, 3};
    int i;
    for (i = 0; i < 6; i++) begin
      set_frame(geo_w[i], geo_h[i], $urandom_range(0, 64));
      send_frame(30, 1'b1, 1'b0, 0);
    end
  endtask

  // Frames back to back with no frame start: counters wrap on their own.
  // Then break a frame off part way and restart it.
  task automatic test_frame_wrap();
    set_frame(5, 6, 20);
    send_frame(3 * 30, 1'b1, 1'b1, 25);
    send_frame(13, 1'b1, 1'b0, 0);
    send_frame(30, 1'b1, 1'b1, 25);
  endtask

  // Receiver holds off long enough for the block to stall its input, then the
  // sender pauses until every decision has come out.
  task automatic test_output_stall();
    set_frame(8, 30, 24);
    hold_request = 300;
    send_frame(240, 1'b1, 1'b1, 20);
    drain();
  endtask

  // Random geometry and content: mostly whole frames, some cut short, some
  // running on from the previous frame without a frame start.
  task automatic test_random_frames(input int unsigned n_items);
    int unsigned sent, w, h, thr, nframes, npix, f;
    bit          mark, smooth;
    sent = 0;
    while (sent < n_items) begin
      w = ($urandom_range(99) < 10) ? $urandom_range(13, 64) : $urandom_range(5, 12);
      h = $urandom_range(5, 10);
      case ($urandom_range(9))
        0:       thr = $urandom_range(0, 256);
        1:       thr = $urandom_range(257, 511);
        default: thr = $urandom_range(0, 64);
      endcase
      set_frame(w, h, thr);
      nframes = $urandom_range(1, 3);
      for (f = 0; f < nframes; f++) begin
        npix   = ($urandom_range(99) < 15) ? $urandom_range(1, w * h - 1) : w * h;
        mark   = (f == 0) || ($urandom_range(99) >= 10);
        smooth = ($urandom_range(99) < 70);
        send_frame(npix, mark, smooth, $urandom_range(0, 40));
        sent += npix;
      end
    end
  endtask

  // Oversized width, capped to the line store: a stretch of the first line
  // must not wrap early.
  task automatic test_widest_frame();
    set_frame(4095, 5, 40);
    send_frame(96, 1'b1, 1'b1, 30);
  endtask

  // Oversized height, capped at the row limit: rows past the register's low
  // bits keep deciding.
  task automatic test_tallest_frame();
    set_frame(5, 8191, 48);
    send_frame(5 * 12 + 7, 1'b1, 1'b1, 30);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sender mostly busy, receiver mostly stalling
    send_idle_pct = 12;
    recv_idle_pct = 86;
    test_minimal_frames();
    test_threshold_extremes();
    test_degenerate_geometry();
    test_frame_wrap();
    test_output_stall();

    // swap: sender sparse, receiver eager
    send_idle_pct = 86;
    recv_idle_pct = 12;
    test_random_frames(280);

    // full rate both ways
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_frames(300);
    test_widest_frame();
    test_tallest_frame();

    drain();
    repeat (EndCycles) @(posedge clk_i);
    if (fault_count == 0 && pending_centres.size() == 0) begin
      $display("neighbourhood_mean_edge_threshold verification clean");
    end else begin
      $display("neighbourhood_mean_edge_threshold verification failed");
    end
    $finish;
  end

endmodule

// ----- neighbourhood_mean_edge_threshold.f -----
rtl/core/nmet_pkg.sv
rtl/core/nmet_decide.sv
rtl/core/neighbourhood_mean_edge_threshold.sv
dv/testbench.sv
